>>> rtl/tsfc_pkg.sv
package tsfc_pkg;

  // Fixed field widths
  localparam int unsigned COORD_W    = 32;
  localparam int unsigned MAG_W      = COORD_W + 3;
  localparam int unsigned LIM_W      = 31;
  localparam int unsigned WGT_W      = 16;
  localparam int unsigned PER_W      = 32;
  localparam int unsigned RES_W      = 48;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // Fraction shifts of the fixed-point products
  localparam int unsigned SH_FIX = 16;
  localparam int unsigned SH_WGT = 8;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_INV_PERIOD  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OUTER_LIMIT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VEL_LIMIT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ACC_LIMIT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_JERK_LIMIT  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_VEL_WEIGHT  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ACC_WEIGHT  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_JERK_WEIGHT = 3'd7;

  // Register reset values
  localparam logic [PER_W-1:0] RST_INV_PERIOD = 32'd655360;
  localparam logic [LIM_W-1:0] RST_LIMIT      = 31'd65536;
  localparam logic [WGT_W-1:0] RST_WEIGHT     = 16'd256;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [MAG_W-1:0] mag_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
    logic signed [COORD_W-1:0] coord_z;
    logic                      last_point;
  } in_item_t;

  typedef struct packed {
    logic [RES_W-1:0] smooth_cost;
    logic [RES_W-1:0] feasibility_cost;
    logic             cost_saturated;
  } out_item_t;

  typedef struct packed {
    logic [PER_W-1:0] inv_period;
    logic [LIM_W-1:0] outer_limit;
    logic [LIM_W-1:0] vel_limit;
    logic [LIM_W-1:0] acc_limit;
    logic [LIM_W-1:0] jerk_limit;
    logic [WGT_W-1:0] vel_weight;
    logic [WGT_W-1:0] acc_weight;
    logic [WGT_W-1:0] jerk_weight;
  } cfg_t;

  // One classified point: difference magnitudes indexed [order][axis]
  typedef struct packed {
    mag_t [2:0][2:0] mag;
    logic [1:0]      level;
    logic            last;
  } work_t;

endpackage

>>> rtl/trajectory_smooth_feasibility_cost.sv
// An accepted point enters the queue; the back then runs a
// pass on one shared multiplier, 4 partial products per multiply,
// up to 72 multiplies for a point with full history. A pass's length depends
// on history depth and data; a last point's result is registered at its end.
// Throughput: one point per back pass; a two-entry queue decouples the sides.
// Reset (rst_ni low, async): history, sums and queues cleared, registers default.
module trajectory_smooth_feasibility_cost import tsfc_pkg::*; #(
  parameter int unsigned COST_WIDTH = 48
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push,
  output logic                  full,
  input  in_item_t              point_i,
  output logic                  empty,
  input  logic                  pop,
  output out_item_t             result_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  cfg_t       cfg_q;
  work_t      work_in, work_out;
  logic       accept, work_pop, fifo_empty;
  logic [1:0] fifo_cnt;

  assign accept      = push & ~full;
  assign cfg_ready_o = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.inv_period  <= RST_INV_PERIOD;
      cfg_q.outer_limit <= RST_LIMIT;
      cfg_q.vel_limit   <= RST_LIMIT;
      cfg_q.acc_limit   <= RST_LIMIT;
      cfg_q.jerk_limit  <= RST_LIMIT;
      cfg_q.vel_weight  <= RST_WEIGHT;
      cfg_q.acc_weight  <= RST_WEIGHT;
      cfg_q.jerk_weight <= RST_WEIGHT;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_INV_PERIOD:  cfg_q.inv_period  <= cfg_data_i;
        REG_OUTER_LIMIT: cfg_q.outer_limit <= cfg_data_i[LIM_W-1:0];
        REG_VEL_LIMIT:   cfg_q.vel_limit   <= cfg_data_i[LIM_W-1:0];
        REG_ACC_LIMIT:   cfg_q.acc_limit   <= cfg_data_i[LIM_W-1:0];
        REG_JERK_LIMIT:  cfg_q.jerk_limit  <= cfg_data_i[LIM_W-1:0];
        REG_VEL_WEIGHT:  cfg_q.vel_weight  <= cfg_data_i[WGT_W-1:0];
        REG_ACC_WEIGHT:  cfg_q.acc_weight  <= cfg_data_i[WGT_W-1:0];
        REG_JERK_WEIGHT: cfg_q.jerk_weight <= cfg_data_i[WGT_W-1:0];
        default: ;
      endcase
    end
  end

  tsfc_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .point_i  (point_i),
    .work_o   (work_in)
  );

  tsfc_fifo #(.W($bits(work_t))) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .data_i  (work_in),
    .pop_i   (work_pop),
    .data_o  (work_out),
    .cnt_o   (fifo_cnt),
    .full_o  (full),
    .empty_o (fifo_empty)
  );

  tsfc_back #(.COST_W(COST_WIDTH)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .work_i       (work_out),
    .work_valid_i (~fifo_empty),
    .work_pop_o   (work_pop),
    .result_o     (result_o),
    .empty_o      (empty),
    .pop_i        (pop)
  );

  // an accepted request is visible in the queue next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> fifo_cnt != 2'd0)
    else $error("accepted request lost from queue");

  // the back side only takes work that is there
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    work_pop |-> fifo_cnt != 2'd0)
    else $error("back popped an empty queue");

endmodule

>>> rtl/tsfc_fifo.sv
module tsfc_fifo #(
  parameter int unsigned W = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] data_i,
  input  logic         pop_i,
  output logic [W-1:0] data_o,
  output logic [1:0]   cnt_o,
  output logic         full_o,
  output logic         empty_o
);

  logic [W-1:0] mem_q [2];
  logic         wr_q, rd_q;
  logic [1:0]   cnt_q;

  assign data_o  = mem_q[rd_q];
  assign cnt_o   = cnt_q;
  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);

  // two-entry queue
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i) rd_q <= ~rd_q;
      if (push_i && !pop_i) cnt_q <= cnt_q + 2'd1;
      else if (!push_i && pop_i) cnt_q <= cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

endmodule

>>> rtl/tsfc_front.sv
module tsfc_front import tsfc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     accept_i,
  input  in_item_t point_i,
  output work_t    work_o
);

  localparam int unsigned DW = MAG_W + 1;

  coord_t           hist_q [3][3];
  logic [1:0]       seen_q;
  coord_t           pt [3];
  logic signed [DW-1:0] p, h0, h1, h2, dv, da, dj;

  function automatic mag_t mag_of(input logic signed [DW-1:0] x);
    logic [DW-1:0] ux;
    ux = x[DW-1] ? DW'(-x) : DW'(x);
    return ux[MAG_W-1:0];
  endfunction

  assign pt[0] = point_i.coord_x;
  assign pt[1] = point_i.coord_y;
  assign pt[2] = point_i.coord_z;

  // finite differences per axis
  always_comb begin
    work_o.level = seen_q;
    work_o.last  = point_i.last_point;
    for (int ax = 0; ax < 3; ax++) begin
      p  = DW'(pt[ax]);
      h0 = DW'(hist_q[0][ax]);
      h1 = DW'(hist_q[1][ax]);
      h2 = DW'(hist_q[2][ax]);
      dv = p - h0;
      da = p - (h0 <<< 1) + h1;
      dj = p - (h0 <<< 1) - h0 + (h1 <<< 1) + h1 - h2;
      work_o.mag[0][ax] = mag_of(dv);
      work_o.mag[1][ax] = mag_of(da);
      work_o.mag[2][ax] = mag_of(dj);
    end
  end

  // point history; a last point starts a fresh trajectory
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= 2'd0;
      for (int i = 0; i < 3; i++) begin
        for (int ax = 0; ax < 3; ax++) begin
          hist_q[i][ax] <= '0;
        end
      end
    end else if (accept_i) begin
      if (point_i.last_point) begin
        seen_q <= 2'd0;
        for (int i = 0; i < 3; i++) begin
          for (int ax = 0; ax < 3; ax++) begin
            hist_q[i][ax] <= '0;
          end
        end
      end else begin
        if (seen_q != 2'd3) seen_q <= seen_q + 2'd1;
        for (int ax = 0; ax < 3; ax++) begin
          hist_q[2][ax] <= hist_q[1][ax];
          hist_q[1][ax] <= hist_q[0][ax];
          hist_q[0][ax] <= pt[ax];
        end
      end
    end
  end

endmodule

>>> rtl/tsfc_mul.sv
module tsfc_mul import tsfc_pkg::*; #(
  parameter int unsigned OPW    = 48,
  parameter int unsigned COST_W = 48
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [OPW-1:0]    a_i,
  input  logic [OPW-1:0]    b_i,
  input  logic              sh8_i,
  output logic              done_o,
  output logic [COST_W-1:0] res_o,
  output logic              sat_o
);

  localparam int unsigned HW = (OPW + 1) / 2;
  localparam int unsigned PW = 4 * HW;
  localparam logic [PW-1:0] MAXW = PW'({COST_W{1'b1}});

  logic [2*HW-1:0] a_q, b_q, pp;
  logic [HW-1:0]   ah, bh;
  logic [PW-1:0]   acc_q, pp_sh, acc_sh;
  logic [1:0]      cnt_q;
  logic            busy_q, done_q, sh8_q;

  // one partial product a cycle
  always_comb begin
    ah = cnt_q[0] ? a_q[2*HW-1:HW] : a_q[HW-1:0];
    bh = cnt_q[1] ? b_q[2*HW-1:HW] : b_q[HW-1:0];
    pp = {{HW{1'b0}}, ah} * {{HW{1'b0}}, bh};
    case (cnt_q) inside
      2'd0:       pp_sh = PW'(pp);
      2'd1, 2'd2: pp_sh = PW'(pp) << HW;
      default:    pp_sh = PW'(pp) << (2 * HW);
    endcase
  end

  // truncate the fraction and clamp
  always_comb begin
    acc_sh = sh8_q ? (acc_q >> SH_WGT) : (acc_q >> SH_FIX);
    sat_o  = (acc_sh > MAXW);
    res_o  = sat_o ? {COST_W{1'b1}} : acc_sh[COST_W-1:0];
  end

  assign done_o = done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q    <= '0;
      b_q    <= '0;
      acc_q  <= '0;
      cnt_q  <= 2'd0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
      sh8_q  <= 1'b0;
    end else if (start_i) begin
      a_q    <= (2*HW)'(a_i);
      b_q    <= (2*HW)'(b_i);
      acc_q  <= '0;
      cnt_q  <= 2'd0;
      busy_q <= 1'b1;
      done_q <= 1'b0;
      sh8_q  <= sh8_i;
    end else if (busy_q) begin
      acc_q <= acc_q + pp_sh;
      cnt_q <= cnt_q + 2'd1;
      if (cnt_q == 2'd3) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

endmodule

>>> rtl/tsfc_back.sv
module tsfc_back import tsfc_pkg::*; #(
  parameter int unsigned COST_W = 48
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  work_t     work_i,
  input  logic      work_valid_i,
  output logic      work_pop_o,
  output out_item_t result_o,
  output logic      empty_o,
  input  logic      pop_i
);

  localparam int unsigned OPW = (COST_W > MAG_W) ? COST_W : MAG_W;
  localparam int unsigned EW  = (COST_W > RES_W) ? COST_W : RES_W;
  localparam logic [COST_W-1:0] MAX = {COST_W{1'b1}};

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_TERM  = 4'd1;
  localparam logic [3:0] ST_SCALE = 4'd2;
  localparam logic [3:0] ST_SQ    = 4'd3;
  localparam logic [3:0] ST_CLS   = 4'd4;
  localparam logic [3:0] ST_C1    = 4'd5;
  localparam logic [3:0] ST_C2    = 4'd6;
  localparam logic [3:0] ST_Q1    = 4'd7;
  localparam logic [3:0] ST_Q2    = 4'd8;
  localparam logic [3:0] ST_Q3    = 4'd9;
  localparam logic [3:0] ST_Q4    = 4'd10;
  localparam logic [3:0] ST_Q5    = 4'd11;
  localparam logic [3:0] ST_NEXT  = 4'd12;
  localparam logic [3:0] ST_WGT   = 4'd13;
  localparam logic [3:0] ST_FIN   = 4'd14;

  logic [3:0]        st_q, st_d;
  work_t             wk_q, wk_d;
  logic [1:0]        ord_q, ord_d, ax_q, ax_d, k_q, k_d;
  logic [OPW-1:0]    m_q, m_d, u_q, u_d, e_q, e_d;
  logic [COST_W-1:0] d2_q, d2_d, f_q, f_d, smooth_q, smooth_d, feas_q, feas_d;
  logic              sat_q, sat_d;
  out_item_t         out_q, out_d;
  logic              out_valid_q, out_valid_d;

  logic              mul_start, mul_sh8, mul_done, mul_sat;
  logic [OPW-1:0]    mul_a, mul_b, res_w, lim_w, c_w, inv_w;
  logic [COST_W-1:0] mul_res;
  logic [COST_W+1:0] res3;
  logic [COST_W:0]   sa;
  logic [WGT_W-1:0]  wgt;
  logic [EW-1:0]     smooth_ext, feas_ext;

  // saturating add, flag in the top bit
  function automatic logic [COST_W:0] sat_add(input logic [COST_W-1:0] a,
                                              input logic [COST_W+1:0] b);
    logic [COST_W+2:0] s;
    s = {3'b000, a} + {1'b0, b};
    if (s > {3'b000, MAX}) return {1'b1, MAX};
    return {1'b0, s[COST_W-1:0]};
  endfunction

  tsfc_mul #(.OPW(OPW), .COST_W(COST_W)) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .sh8_i   (mul_sh8),
    .done_o  (mul_done),
    .res_o   (mul_res),
    .sat_o   (mul_sat)
  );

  // per-order limit and weight
  always_comb begin
    case (ord_q)
      2'd0:    begin lim_w = OPW'(cfg_i.vel_limit);  wgt = cfg_i.vel_weight;  end
      2'd1:    begin lim_w = OPW'(cfg_i.acc_limit);  wgt = cfg_i.acc_weight;  end
      default: begin lim_w = OPW'(cfg_i.jerk_limit); wgt = cfg_i.jerk_weight; end
    endcase
  end

  assign c_w        = OPW'(cfg_i.outer_limit);
  assign inv_w      = OPW'(cfg_i.inv_period);
  assign res_w      = OPW'(mul_res);
  assign res3       = {2'b00, mul_res} + {1'b0, mul_res, 1'b0};
  assign smooth_ext = EW'(smooth_q);
  assign feas_ext   = EW'(feas_q);

  // sequencer
  always_comb begin
    st_d        = st_q;
    wk_d        = wk_q;
    ord_d       = ord_q;
    ax_d        = ax_q;
    k_d         = k_q;
    m_d         = m_q;
    u_d         = u_q;
    e_d         = e_q;
    d2_d        = d2_q;
    f_d         = f_q;
    smooth_d    = smooth_q;
    feas_d      = feas_q;
    sat_d       = sat_q | (mul_done & mul_sat);
    out_d       = out_q;
    out_valid_d = out_valid_q & ~pop_i;
    mul_start   = 1'b0;
    mul_a       = '0;
    mul_b       = '0;
    mul_sh8     = 1'b0;
    work_pop_o  = 1'b0;
    sa          = '0;
    unique case (st_q)
      ST_IDLE: begin
        if (work_valid_i) begin
          wk_d       = work_i;
          work_pop_o = 1'b1;
          ord_d      = 2'd0;
          ax_d       = 2'd0;
          f_d        = '0;
          st_d       = ST_TERM;
        end
      end
      ST_TERM: begin
        if (wk_q.level > ord_q) begin
          m_d       = OPW'(wk_q.mag[ord_q][ax_q]);
          k_d       = 2'd0;
          mul_start = 1'b1;
          mul_a     = OPW'(wk_q.mag[ord_q][ax_q]);
          mul_b     = inv_w;
          st_d      = ST_SCALE;
        end else begin
          st_d = ST_FIN;
        end
      end
      ST_SCALE: begin
        if (mul_done) begin
          m_d = res_w;
          if (k_q != ord_q) begin
            k_d       = k_q + 2'd1;
            mul_start = 1'b1;
            mul_a     = res_w;
            mul_b     = inv_w;
          end else if (ord_q != 2'd0) begin
            mul_start = 1'b1;
            mul_a     = res_w;
            mul_b     = res_w;
            st_d      = ST_SQ;
          end else begin
            st_d = ST_CLS;
          end
        end
      end
      ST_SQ: begin
        if (mul_done) begin
          sa       = sat_add(smooth_q, {2'b00, mul_res});
          smooth_d = sa[COST_W-1:0];
          sat_d    = sat_d | sa[COST_W];
          st_d     = ST_CLS;
        end
      end
      ST_CLS: begin
        if (m_q <= lim_w) begin
          st_d = ST_NEXT;
        end else if (c_w <= lim_w || m_q < c_w) begin
          u_d       = m_q - lim_w;
          mul_start = 1'b1;
          mul_a     = m_q - lim_w;
          mul_b     = m_q - lim_w;
          st_d      = ST_C1;
        end else begin
          u_d       = c_w - lim_w;
          e_d       = m_q - c_w;
          mul_start = 1'b1;
          mul_a     = c_w - lim_w;
          mul_b     = c_w - lim_w;
          st_d      = ST_Q1;
        end
      end
      ST_C1: begin
        if (mul_done) begin
          mul_start = 1'b1;
          mul_a     = res_w;
          mul_b     = u_q;
          st_d      = ST_C2;
        end
      end
      ST_C2: begin
        if (mul_done) begin
          sa    = sat_add(f_q, {2'b00, mul_res});
          f_d   = sa[COST_W-1:0];
          sat_d = sat_d | sa[COST_W];
          st_d  = ST_NEXT;
        end
      end
      ST_Q1: begin
        if (mul_done) begin
          d2_d      = mul_res;
          mul_start = 1'b1;
          mul_a     = res_w;
          mul_b     = u_q;
          st_d      = ST_Q2;
        end
      end
      ST_Q2: begin
        if (mul_done) begin
          sa        = sat_add(f_q, {2'b00, mul_res});
          f_d       = sa[COST_W-1:0];
          sat_d     = sat_d | sa[COST_W];
          mul_start = 1'b1;
          mul_a     = OPW'(d2_q);
          mul_b     = e_q;
          st_d      = ST_Q3;
        end
      end
      ST_Q3: begin
        if (mul_done) begin
          sa        = sat_add(f_q, res3);
          f_d       = sa[COST_W-1:0];
          sat_d     = sat_d | sa[COST_W];
          mul_start = 1'b1;
          mul_a     = e_q;
          mul_b     = e_q;
          st_d      = ST_Q4;
        end
      end
      ST_Q4: begin
        if (mul_done) begin
          mul_start = 1'b1;
          mul_a     = u_q;
          mul_b     = res_w;
          st_d      = ST_Q5;
        end
      end
      ST_Q5: begin
        if (mul_done) begin
          sa    = sat_add(f_q, res3);
          f_d   = sa[COST_W-1:0];
          sat_d = sat_d | sa[COST_W];
          st_d  = ST_NEXT;
        end
      end
      ST_NEXT: begin
        if (ax_q == 2'd2) begin
          ax_d      = 2'd0;
          mul_start = 1'b1;
          mul_a     = OPW'(f_q);
          mul_b     = OPW'(wgt);
          mul_sh8   = 1'b1;
          st_d      = ST_WGT;
        end else begin
          ax_d = ax_q + 2'd1;
          st_d = ST_TERM;
        end
      end
      ST_WGT: begin
        if (mul_done) begin
          sa     = sat_add(feas_q, {2'b00, mul_res});
          feas_d = sa[COST_W-1:0];
          sat_d  = sat_d | sa[COST_W];
          f_d    = '0;
          if (ord_q == 2'd2) begin
            st_d = ST_FIN;
          end else begin
            ord_d = ord_q + 2'd1;
            st_d  = ST_TERM;
          end
        end
      end
      ST_FIN: begin
        if (!wk_q.last) begin
          st_d = ST_IDLE;
        end else if (!out_valid_q || pop_i) begin
          out_d.smooth_cost      = smooth_ext[RES_W-1:0];
          out_d.feasibility_cost = feas_ext[RES_W-1:0];
          out_d.cost_saturated   = sat_q;
          out_valid_d            = 1'b1;
          smooth_d               = '0;
          feas_d                 = '0;
          sat_d                  = 1'b0;
          st_d                   = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      ord_q       <= 2'd0;
      ax_q        <= 2'd0;
      k_q         <= 2'd0;
      f_q         <= '0;
      smooth_q    <= '0;
      feas_q      <= '0;
      sat_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      ord_q       <= ord_d;
      ax_q        <= ax_d;
      k_q         <= k_d;
      f_q         <= f_d;
      smooth_q    <= smooth_d;
      feas_q      <= feas_d;
      sat_q       <= sat_d;
      out_valid_q <= out_valid_d;
    end
  end

  // operand and result registers
  always_ff @(posedge clk_i) begin
    wk_q  <= wk_d;
    m_q   <= m_d;
    u_q   <= u_d;
    e_q   <= e_d;
    d2_q  <= d2_d;
    out_q <= out_d;
  end

  assign result_o = out_q;
  assign empty_o  = ~out_valid_q;

endmodule

>>> tb/trajectory_smooth_feasibility_cost_tb.sv
`timescale 1ns / 100ps

module trajectory_smooth_feasibility_cost_tb;
  import tsfc_pkg::*;

  localparam logic [63:0] COST_MAX = (64'd1 << RES_W) - 64'd1;
  localparam int unsigned DRAIN_CYCLES = 1000;
  localparam int unsigned HOLD_CYCLES = 3000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic full;
  in_item_t point_i = '0;
  logic empty;
  logic pop = 1'b0;
  out_item_t result_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  trajectory_smooth_feasibility_cost uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .push(push), .full(full), .point_i(point_i),
    .empty(empty), .pop(pop), .result_o(result_o),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i), .cfg_data_i(cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Local copy of the register file
  logic [63:0] rate, outer_lim, vel_lim, acc_lim, jerk_lim;
  logic [63:0] vel_wgt, acc_wgt, jerk_wgt;

  // Trajectory state of the cost model
  longint hist [3][3];
  int unsigned pts_seen;
  logic [63:0] smooth_acc, feas_acc;
  bit clamp_seen;

  out_item_t cost_q[$];
  int unsigned mismatches = 0;
  bit calm = 1'b0;
  bit hold_req = 1'b0;

  // Truncating fixed-point product, clamped at the cost width
  function automatic logic [63:0] cost_mul(logic [63:0] a, logic [63:0] b, int unsigned sh);
    logic [127:0] p;
    p = ({64'd0, a} * {64'd0, b}) >> sh;
    if (p > {64'd0, COST_MAX}) begin
      clamp_seen = 1'b1;
      return COST_MAX;
    end
    return p[63:0];
  endfunction

  function automatic logic [63:0] cost_add(logic [63:0] a, logic [63:0] b);
    if (a > COST_MAX || b > COST_MAX - a) begin
      clamp_seen = 1'b1;
      return COST_MAX;
    end
    return a + b;
  endfunction

  function automatic logic [63:0] cube_of(logic [63:0] x);
    return cost_mul(cost_mul(x, x, SH_FIX), x, SH_FIX);
  endfunction

  // Dead zone, cubic band, then quadratic continuation past the outer limit
  function automatic logic [63:0] axis_penalty(logic [63:0] u, logic [63:0] lim);
    logic [63:0] d, e, d2, e2, t, x;
    if (u <= lim) return 64'd0;
    if (outer_lim <= lim || u < outer_lim) return cube_of(u - lim);
    d = outer_lim - lim;
    e = u - outer_lim;
    d2 = cost_mul(d, d, SH_FIX);
    e2 = cost_mul(e, e, SH_FIX);
    t = cost_mul(d2, d, SH_FIX);
    x = cost_mul(d2, e, SH_FIX);
    t = cost_add(t, cost_add(x, cost_add(x, x)));
    x = cost_mul(d, e2, SH_FIX);
    t = cost_add(t, cost_add(x, cost_add(x, x)));
    return t;
  endfunction

  function automatic logic [63:0] rate_scaled(longint diff, int unsigned order);
    logic [63:0] m;
    m = (diff < 0) ? 64'(-diff) : 64'(diff);
    for (int k = 0; k < order; k++) m = cost_mul(m, rate, SH_FIX);
    return m;
  endfunction

  task automatic predict_costs(input in_item_t pt, output bit emits, output out_item_t res);
    longint p [3];
    logic [63:0] fv, fa, fj, m;
    fv = 0; fa = 0; fj = 0;
    p[0] = longint'(pt.coord_x);
    p[1] = longint'(pt.coord_y);
    p[2] = longint'(pt.coord_z);
    for (int ax = 0; ax < 3; ax++) begin
      if (pts_seen >= 1) begin
        m = rate_scaled(p[ax] - hist[0][ax], 1);
        fv = cost_add(fv, axis_penalty(m, vel_lim));
      end
      if (pts_seen >= 2) begin
        m = rate_scaled(p[ax] - 2 * hist[0][ax] + hist[1][ax], 2);
        smooth_acc = cost_add(smooth_acc, cost_mul(m, m, SH_FIX));
        fa = cost_add(fa, axis_penalty(m, acc_lim));
      end
      if (pts_seen >= 3) begin
        m = rate_scaled(p[ax] - 3 * hist[0][ax] + 3 * hist[1][ax] - hist[2][ax], 3);
        smooth_acc = cost_add(smooth_acc, cost_mul(m, m, SH_FIX));
        fj = cost_add(fj, axis_penalty(m, jerk_lim));
      end
    end
    feas_acc = cost_add(feas_acc, cost_mul(fv, vel_wgt, SH_WGT));
    feas_acc = cost_add(feas_acc, cost_mul(fa, acc_wgt, SH_WGT));
    feas_acc = cost_add(feas_acc, cost_mul(fj, jerk_wgt, SH_WGT));
    for (int ax = 0; ax < 3; ax++) begin
      hist[2][ax] = hist[1][ax];
      hist[1][ax] = hist[0][ax];
      hist[0][ax] = p[ax];
    end
    if (pts_seen < 3) pts_seen++;
    emits = pt.last_point;
    res = '0;
    if (emits) begin
      res.smooth_cost = smooth_acc[RES_W-1:0];
      res.feasibility_cost = feas_acc[RES_W-1:0];
      res.cost_saturated = clamp_seen;
      hist = '{default: 0};
      pts_seen = 0;
      smooth_acc = 0;
      feas_acc = 0;
      clamp_seen = 1'b0;
    end
  endtask

  // Register write; valid stays high across back-to-back writes
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_INV_PERIOD:  rate = 64'(val);
      REG_OUTER_LIMIT: outer_lim = 64'(val[LIM_W-1:0]);
      REG_VEL_LIMIT:   vel_lim = 64'(val[LIM_W-1:0]);
      REG_ACC_LIMIT:   acc_lim = 64'(val[LIM_W-1:0]);
      REG_JERK_LIMIT:  jerk_lim = 64'(val[LIM_W-1:0]);
      REG_VEL_WEIGHT:  vel_wgt = 64'(val[WGT_W-1:0]);
      REG_ACC_WEIGHT:  acc_wgt = 64'(val[WGT_W-1:0]);
      default:         jerk_wgt = 64'(val[WGT_W-1:0]);
    endcase
  endtask

  task automatic cfg_set_all(input logic [CFG_DATA_W-1:0] vals [8]);
    for (int i = 0; i < 8; i++) cfg_write(CFG_IDX_W'(i), vals[i]);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Wait for all pending costs, then let the back end settle
  task automatic settle();
    while (cost_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Offer one point with optional idle burst; typed expectation overrides
  task automatic send_point(input in_item_t pt, input bit typed, input out_item_t want);
    bit emits;
    out_item_t res;
    @(negedge clk_i);
    if (!calm && $urandom_range(0, 3) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk_i);
    end
    push <= 1'b1;
    point_i <= pt;
    do @(posedge clk_i); while (full);
    predict_costs(pt, emits, res);
    if (emits) cost_q = {cost_q, (typed ? want : res)};
  endtask

  function automatic logic [31:0] rand_coord(int mode, logic [31:0] prev);
    logic [31:0] step;
    case (mode)
      0: begin
        step = $urandom >> $urandom_range(6, 31);
        return $urandom_range(0, 1) ? prev + step : prev - step;
      end
      1: return $urandom;
      default: begin
        case ($urandom_range(0, 3))
          0: return 32'h8000_0000;
          1: return 32'h7fff_ffff;
          2: return 32'hffff_ffff;
          default: return 32'h0;
        endcase
      end
    endcase
  endfunction

  // Directed rows
  typedef struct {
    in_item_t pt;
    bit typed;
    out_item_t want;
  } drow_t;
  drow_t drows[$];

  task automatic add_row(input logic [31:0] x, y, z, input bit lp, input bit typed,
                         input out_item_t want);
    drow_t r;
    r.pt = '{coord_x: x, coord_y: y, coord_z: z, last_point: lp};
    r.typed = typed;
    r.want = want;
    drows = {drows, r};
  endtask

  // Result checking
  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      if (cost_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", result_o);
      end else begin
        out_item_t w;
        w = cost_q.pop_front();
        if (result_o.smooth_cost !== w.smooth_cost ||
            result_o.feasibility_cost !== w.feasibility_cost ||
            result_o.cost_saturated !== w.cost_saturated) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp smooth=%h feas=%h sat=%b got smooth=%h feas=%h sat=%b",
                     w.smooth_cost, w.feasibility_cost, w.cost_saturated,
                     result_o.smooth_cost, result_o.feasibility_cost,
                     result_o.cost_saturated);
        end
      end
    end
  end

  // Receiver: random stall bursts, one long hold-off on request
  initial begin
    int unsigned stall;
    stall = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        stall = HOLD_CYCLES;
      end else if (stall == 0 && !calm && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 17);
      end
      if (stall != 0) begin
        pop <= 1'b0;
        stall--;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Stimulus
  initial begin
    out_item_t none, zero_cost, sat_cost;
    logic [CFG_DATA_W-1:0] vals [8];
    logic [31:0] cx, cy, cz;
    int mode, len, phases;
    int unsigned sent;
    none = '0;
    zero_cost = '0;
    sat_cost = '{smooth_cost: COST_MAX[RES_W-1:0], feasibility_cost: COST_MAX[RES_W-1:0],
                 cost_saturated: 1'b1};
    rate = 64'(RST_INV_PERIOD);
    outer_lim = 64'(RST_LIMIT); vel_lim = 64'(RST_LIMIT);
    acc_lim = 64'(RST_LIMIT); jerk_lim = 64'(RST_LIMIT);
    vel_wgt = 64'(RST_WEIGHT); acc_wgt = 64'(RST_WEIGHT); jerk_wgt = 64'(RST_WEIGHT);
    hist = '{default: 0};
    pts_seen = 0; smooth_acc = 0; feas_acc = 0; clamp_seen = 0;

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Lone last points give zero sums; full-swing points saturate
    add_row(32'h0, 32'h0, 32'h0, 1'b1, 1'b1, zero_cost);
    add_row(32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 1'b1, 1'b1, zero_cost);
    add_row(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0, 1'b0, none);
    add_row(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 1'b0, 1'b0, none);
    add_row(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0, 1'b0, none);
    add_row(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 1'b1, 1'b1, sat_cost);
    // Two points: velocity only
    add_row(32'h0, 32'h0, 32'h0, 1'b0, 1'b0, none);
    add_row(32'h0000_0800, 32'hffff_f800, 32'h0, 1'b1, 1'b0, none);
    // Three points: acceleration enters
    add_row(32'h0, 32'h0, 32'h0, 1'b0, 1'b0, none);
    add_row(32'h0000_1000, 32'h0000_0100, 32'hffff_0000, 1'b0, 1'b0, none);
    add_row(32'h0000_3000, 32'h0000_0300, 32'hfffe_0000, 1'b1, 1'b0, none);
    // Longer trajectory with jerk: x at constant velocity, y at constant acceleration, z cubic
    for (int i = 0; i < 6; i++)
      add_row(32'(i * 32'h1000), 32'(-i * i * 32'h80), 32'(i * i * i * 32'h10),
              1'(i == 5), 1'b0, none);
    foreach (drows[i]) send_point(drows[i].pt, drows[i].typed, drows[i].want);
    @(negedge clk_i);
    push <= 1'b0;
    settle();

    // Random phases, each with its own register setting
    sent = 0;
    phases = 0;
    while (sent < 1500) begin
      case (phases)
        0: vals = '{32'h000a_0000, 32'h0004_0000, 32'h0001_0000, 32'h0001_0000,
                    32'h0001_0000, 32'h0100, 32'h0100, 32'h0100};
        1: vals = '{32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0};
        2: vals = '{32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                    32'hffff_ffff, 32'hffff, 32'hffff, 32'hffff};
        3: vals = '{32'h0001_0000, 32'h7fff_ffff, 32'h0, 32'h0, 32'h0,
                    32'hffff, 32'h1, 32'h80};
        default: begin
          vals[0] = $urandom >> $urandom_range(8, 16);
          vals[1] = $urandom >> $urandom_range(0, 16);
          for (int i = 2; i < 5; i++) vals[i] = $urandom >> $urandom_range(0, 18);
          for (int i = 5; i < 8; i++) vals[i] = $urandom;
        end
      endcase
      cfg_set_all(vals);
      if (phases == 5) hold_req = 1'b1;
      calm = (sent >= 1350);
      for (int t = 0; t < 20 && sent < 1500; t++) begin
        mode = ($urandom_range(0, 9) < 7) ? 0 : $urandom_range(1, 2);
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 9);
        cx = $urandom; cy = $urandom; cz = $urandom;
        for (int k = 0; k < len; k++) begin
          in_item_t pt;
          cx = rand_coord(mode, cx);
          cy = rand_coord(mode, cy);
          cz = rand_coord(mode, cz);
          pt = '{coord_x: cx, coord_y: cy, coord_z: cz, last_point: 1'(k == len - 1)};
          send_point(pt, 1'b0, none);
          sent++;
        end
      end
      @(negedge clk_i);
      push <= 1'b0;
      settle();
      phases++;
    end

    if (mismatches == 0 && cost_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #50_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
